@@ rtl/core/rgbb_pkg.sv @@
// Package for the RGBA window blur: sizes, command and state codes, and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none

package rgbb_pkg;

    localparam int FRAME_SIDE     = 64;
    localparam int MAX_RADIUS     = 7;
    localparam int COEF_FRAC_BITS = 16;

    localparam int COORD_W   = $clog2(FRAME_SIDE);
    localparam int SIDE_W    = COORD_W + 1;
    localparam int RAD_W     = 3;
    localparam int TAP_SIDE  = 2 * MAX_RADIUS + 1;
    localparam int TAP_COUNT = TAP_SIDE * TAP_SIDE;
    localparam int KW        = $clog2(TAP_SIDE);
    localparam int TAP_IDX_W = 8;
    localparam int COEF_W    = COEF_FRAC_BITS + 1;
    localparam int PIX_W     = 32;
    localparam int CH_W      = 8;
    localparam int CH_COUNT  = 4;
    localparam int PROD_W    = COEF_W + CH_W;
    localparam int ACC_W     = PROD_W + $clog2(TAP_COUNT);
    localparam int CMD_W     = 2;
    localparam int CFG_DATA_W = SIDE_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_COEF = 2'd0,
        CMD_LOAD_PIX  = 2'd1,
        CMD_READ      = 2'd2
    } t_cmd;

    typedef enum logic [0:0] {
        CFG_CANVAS_SIZE = 1'b0,
        CFG_BLUR_RADIUS = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic                 start;
        logic                 tap_valid;
        logic [KW-1:0]        kx;
        logic [KW-1:0]        ky;
        logic [TAP_IDX_W-1:0] tap;
        logic                 finish;
    } t_dp_cmd;

    typedef struct packed {
        logic [RAD_W-1:0] radius;
        logic             pipe_busy;
        logic             out_free;
    } t_dp_status;

endpackage

`default_nettype wire

@@ rtl/core/rgbb_in_if.sv @@
// Input channel of the blur block: valid/ready handshake and the command payload.
// Depends on rgbb_pkg for field widths.
`default_nettype none

interface rgbb_in_if;
    logic                                valid;
    logic                                ready;
    logic [rgbb_pkg::CMD_W-1:0]          command;
    logic [rgbb_pkg::COORD_W-1:0]        pos_x;
    logic [rgbb_pkg::COORD_W-1:0]        pos_y;
    logic [rgbb_pkg::PIX_W-1:0]          pixel_rgba;
    logic [rgbb_pkg::TAP_IDX_W-1:0]      coef_index;
    logic [rgbb_pkg::COEF_W-1:0]         coef_value;

    modport source (output valid, command, pos_x, pos_y, pixel_rgba, coef_index,
                    coef_value, input ready);
    modport sink (input valid, command, pos_x, pos_y, pixel_rgba, coef_index,
                  coef_value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rgbb_out_if.sv @@
// Output channel of the blur block: valid/ready handshake and the blurred pixel.
// Depends on rgbb_pkg for field widths.
`default_nettype none

interface rgbb_out_if;
    logic                         valid;
    logic                         ready;
    logic [rgbb_pkg::COORD_W-1:0] out_x;
    logic [rgbb_pkg::COORD_W-1:0] out_y;
    logic [rgbb_pkg::PIX_W-1:0]   blurred_rgba;

    modport source (output valid, out_x, out_y, blurred_rgba, input ready);
    modport sink (input valid, out_x, out_y, blurred_rgba, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rgbb_ctrl.sv @@
// Controller of the blur block: state machine and window tap counters.
// Depends on rgbb_pkg; drives the datapath through t_dp_cmd.
`default_nettype none

module rgbb_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic [rgbb_pkg::CMD_W-1:0] i_in_command,
    input  rgbb_pkg::t_dp_status            i_status,
    output logic                            o_in_ready,
    output rgbb_pkg::t_dp_cmd               o_cmd
);
    import rgbb_pkg::*;

    t_state               r_state, n_state;
    logic [KW-1:0]        r_kx, n_kx;
    logic [KW-1:0]        r_ky, n_ky;
    logic [TAP_IDX_W-1:0] r_tap, n_tap;
    logic [KW-1:0]        last_k;
    logic                 accept;
    logic                 is_read;
    logic                 last_col;
    logic                 last_row;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign is_read  = (t_cmd'(i_in_command) == CMD_READ);
    assign last_k   = KW'({i_status.radius, 1'b0});
    assign last_col = (r_kx == last_k);
    assign last_row = (r_ky == last_k);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && is_read) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (last_col && last_row) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy && i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = (r_state == S_IDLE);
        o_cmd           = '0;
        o_cmd.kx        = r_kx;
        o_cmd.ky        = r_ky;
        o_cmd.tap       = r_tap;
        n_kx            = r_kx;
        n_ky            = r_ky;
        n_tap           = r_tap;
        unique case (r_state)
            S_IDLE: begin
                n_kx        = '0;
                n_ky        = '0;
                n_tap       = '0;
                o_cmd.start = accept && is_read;
            end
            S_RUN: begin
                o_cmd.tap_valid = 1'b1;
                n_tap           = r_tap + 1'b1;
                if (last_col) begin
                    n_kx = '0;
                    n_ky = r_ky + 1'b1;
                end else begin
                    n_kx = r_kx + 1'b1;
                end
            end
            S_DRAIN: begin
                o_cmd.finish = !i_status.pipe_busy && i_status.out_free;
            end
            default: begin
                o_cmd = o_cmd;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kx    <= '0;
            r_ky    <= '0;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_kx    <= n_kx;
            r_ky    <= n_ky;
            r_tap   <= n_tap;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/rgbb_dp.sv @@
// Datapath of the blur block: frame and kernel memories, configuration registers,
// coordinate clamping, four-channel multiply-accumulate and output register.
// Depends on rgbb_pkg; commanded by rgbb_ctrl.
`default_nettype none

module rgbb_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [0:0]                      i_cfg_idx,
    input  wire logic [rgbb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_accept,
    input  wire logic [rgbb_pkg::CMD_W-1:0]      i_command,
    input  wire logic [rgbb_pkg::COORD_W-1:0]    i_pos_x,
    input  wire logic [rgbb_pkg::COORD_W-1:0]    i_pos_y,
    input  wire logic [rgbb_pkg::PIX_W-1:0]      i_pixel_rgba,
    input  wire logic [rgbb_pkg::TAP_IDX_W-1:0]  i_coef_index,
    input  wire logic [rgbb_pkg::COEF_W-1:0]     i_coef_value,
    input  rgbb_pkg::t_dp_cmd                    i_cmd,
    output rgbb_pkg::t_dp_status                 o_status,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output logic [rgbb_pkg::COORD_W-1:0]         o_out_x,
    output logic [rgbb_pkg::COORD_W-1:0]         o_out_y,
    output logic [rgbb_pkg::PIX_W-1:0]           o_blurred_rgba
);
    import rgbb_pkg::*;

    logic [PIX_W-1:0]  frame_mem [FRAME_SIDE*FRAME_SIDE];
    logic [COEF_W-1:0] kernel_mem [TAP_COUNT];

    logic [SIDE_W-1:0]    r_canvas_size;
    logic [RAD_W-1:0]     r_blur_radius;
    logic [SIDE_W-1:0]    side;
    logic [RAD_W-1:0]     rad;
    logic [COORD_W-1:0]   r_px, r_py;
    logic [COORD_W-1:0]   nx, ny;
    logic [PIX_W-1:0]     r_pix;
    logic [COEF_W-1:0]    r_coef;
    logic                 r_v1, r_v2;
    logic [PROD_W-1:0]    r_prod [CH_COUNT];
    logic [ACC_W-1:0]     r_acc [CH_COUNT];
    logic [PIX_W-1:0]     sat_rgba;
    logic                 r_out_valid;
    logic [COORD_W-1:0]   r_out_x, r_out_y;
    logic [PIX_W-1:0]     r_out_rgba;

    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic [COORD_W-1:0] p,
        input logic [KW-1:0]      k,
        input logic [RAD_W-1:0]   r,
        input logic [SIDE_W-1:0]  s
    );
        logic signed [COORD_W+1:0] c;
        logic [SIDE_W-1:0]         s_m1;
        c    = $signed({2'b00, p}) + $signed({{(COORD_W+2-KW){1'b0}}, k})
             - $signed({{(COORD_W+2-RAD_W){1'b0}}, r});
        s_m1 = s - 1'b1;
        if (c < 0) begin
            return '0;
        end else if (c >= $signed({1'b0, s})) begin
            return s_m1[COORD_W-1:0];
        end else begin
            return c[COORD_W-1:0];
        end
    endfunction

    always_comb begin
        if (r_canvas_size == '0) begin
            side = SIDE_W'(1);
        end else if (r_canvas_size > SIDE_W'(FRAME_SIDE)) begin
            side = SIDE_W'(FRAME_SIDE);
        end else begin
            side = r_canvas_size;
        end
        if (r_blur_radius > RAD_W'(MAX_RADIUS)) begin
            rad = RAD_W'(MAX_RADIUS);
        end else begin
            rad = r_blur_radius;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_size <= SIDE_W'(FRAME_SIDE);
            r_blur_radius <= RAD_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_CANVAS_SIZE: r_canvas_size <= i_cfg_data;
                CFG_BLUR_RADIUS: r_blur_radius <= i_cfg_data[RAD_W-1:0];
                default: r_canvas_size <= r_canvas_size;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && (t_cmd'(i_command) == CMD_LOAD_PIX)) begin
            frame_mem[{i_pos_y, i_pos_x}] <= i_pixel_rgba;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && (t_cmd'(i_command) == CMD_LOAD_COEF)
                && (i_coef_index < TAP_IDX_W'(TAP_COUNT))) begin
            kernel_mem[i_coef_index] <= i_coef_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
        end
    end

    assign nx = clamp_coord(r_px, i_cmd.kx, rad, side);
    assign ny = clamp_coord(r_py, i_cmd.ky, rad, side);

    always_ff @(posedge i_clk) begin
        if (i_cmd.tap_valid) begin
            r_pix  <= frame_mem[{ny, nx}];
            r_coef <= kernel_mem[i_cmd.tap];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < CH_COUNT; ch++) begin
            r_prod[ch] <= PROD_W'(r_coef) * PROD_W'(r_pix[CH_W*ch +: CH_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < CH_COUNT; ch++) begin
            if (i_cmd.start) begin
                r_acc[ch] <= '0;
            end else if (r_v2) begin
                r_acc[ch] <= r_acc[ch] + ACC_W'(r_prod[ch]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.tap_valid;
            r_v2 <= r_v1;
        end
    end

    always_comb begin
        for (int ch = 0; ch < CH_COUNT; ch++) begin
            if (|r_acc[ch][ACC_W-1:COEF_FRAC_BITS+CH_W]) begin
                sat_rgba[CH_W*ch +: CH_W] = '1;
            end else begin
                sat_rgba[CH_W*ch +: CH_W] = r_acc[ch][COEF_FRAC_BITS +: CH_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_x    <= r_px;
            r_out_y    <= r_py;
            r_out_rgba <= sat_rgba;
        end
    end

    assign o_status.radius    = rad;
    assign o_status.pipe_busy = r_v1 || r_v2;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_out_x        = r_out_x;
    assign o_out_y        = r_out_y;
    assign o_blurred_rgba = r_out_rgba;

endmodule

`default_nettype wire

@@ rtl/core/rgba_gaussian_blur_clamped.sv @@
// Top level of the RGBA window blur with clamped edges.
// Depends on rgbb_pkg, rgbb_in_if, rgbb_out_if, rgbb_ctrl and rgbb_dp.
//
// Items arrive on i_pix_in with a valid/ready handshake. A load coefficient
// or load pixel item writes one kernel tap (if its index is below 225) or one
// frame pixel; it produces no result. A read item returns one blurred pixel on
// o_pix_out, echoing its position.
// A read walks the (2r+1)^2 window one tap per cycle through a single frame
// memory read port, all four channels in parallel; each tap then passes the
// fetch, product and accumulator registers, and the sum goes to the output
// register. Input ready stays low during that walk.
// The result sits in an output register; while the receiver stalls, loads
// are still accepted, and a following read completes its walk and then waits
// until the held result is taken.
// Configuration (canvas size, blur radius) is written through i_cfg_* while
// the block is idle: a rule for the user, which the block does not enforce.
// Reset sets canvas size 64 and radius 1 and empties the pipeline; the frame
// and kernel memories keep their contents and must be loaded before use.
`default_nettype none

module rgba_gaussian_blur_clamped (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [0:0]                      i_cfg_idx,
    input  wire logic [rgbb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rgbb_in_if.sink                              i_pix_in,
    rgbb_out_if.source                           o_pix_out
);
    import rgbb_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       in_ready;
    logic       in_accept;

    assign i_pix_in.ready = in_ready;
    assign in_accept      = i_pix_in.valid && in_ready;

    rgbb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_pix_in.valid),
        .i_in_command (i_pix_in.command),
        .i_status     (dp_status),
        .o_in_ready   (in_ready),
        .o_cmd        (dp_cmd)
    );

    rgbb_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (in_accept),
        .i_command      (i_pix_in.command),
        .i_pos_x        (i_pix_in.pos_x),
        .i_pos_y        (i_pix_in.pos_y),
        .i_pixel_rgba   (i_pix_in.pixel_rgba),
        .i_coef_index   (i_pix_in.coef_index),
        .i_coef_value   (i_pix_in.coef_value),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .i_out_ready    (o_pix_out.ready),
        .o_out_valid    (o_pix_out.valid),
        .o_out_x        (o_pix_out.out_x),
        .o_out_y        (o_pix_out.out_y),
        .o_blurred_rgba (o_pix_out.blurred_rgba)
    );

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Testbench for rgba_gaussian_blur_clamped: random load and read items with idling on
// both channels, a predictor of every blurred pixel, and a field-by-field result check.
// Depends on rgbb_pkg, rgbb_in_if, rgbb_out_if and the block's RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbb_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int NUM_PHASES      = 10;
    localparam int PHASE_ITEMS     = 85;
    localparam int MIN_PHASE_ITEMS = 20;
    localparam int DRAIN_CYCLES    = 240;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int MAX_REPORTS     = 100;
    localparam int COEF_MAX        = (1 << COEF_W) - 1;
    localparam int UNITY           = 1 << COEF_FRAC_BITS;
    localparam int CFG_PAD_MAX     = (1 << (CFG_DATA_W - RAD_W)) - 1;

    typedef struct {
        logic [CMD_W-1:0]     command;
        logic [COORD_W-1:0]   pos_x;
        logic [COORD_W-1:0]   pos_y;
        logic [PIX_W-1:0]     pixel_rgba;
        logic [TAP_IDX_W-1:0] coef_index;
        logic [COEF_W-1:0]    coef_value;
    } t_blur_cmd;

    typedef struct {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [PIX_W-1:0]   blurred_rgba;
    } t_blur_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [0:0]            i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rgbb_in_if  pix_in();
    rgbb_out_if pix_out();

    rgba_gaussian_blur_clamped dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix_in   (pix_in),
        .o_pix_out  (pix_out)
    );

    logic [PIX_W-1:0]  frame_mem [FRAME_SIDE*FRAME_SIDE];
    logic [COEF_W-1:0] kernel_mem [TAP_COUNT];
    int                cfg_canvas = 64;
    int                cfg_radius = 1;

    bit                gen_pix_set [FRAME_SIDE*FRAME_SIDE];
    bit                gen_tap_set [TAP_COUNT];
    int                last_x = 0;
    int                last_y = 0;
    int                queued_total = 0;

    t_blur_cmd         cmd_q [$];
    t_blur_result      blurred_q [$];
    t_blur_cmd         drv_item;
    t_blur_cmd         seen_cmd;
    t_blur_result      want;

    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                err_count = 0;
    int                idle_cycles = 0;

    always #6 i_clk = ~i_clk;

    function automatic int eff_side();
        if (cfg_canvas == 0) return 1;
        if (cfg_canvas > FRAME_SIDE) return FRAME_SIDE;
        return cfg_canvas;
    endfunction

    function automatic int clamp_coord(input int c, input int side);
        if (c < 0) return 0;
        if (c >= side) return side - 1;
        return c;
    endfunction

    function automatic logic [2*COORD_W-1:0] pix_addr(input int x, input int y);
        return {COORD_W'(y), COORD_W'(x)};
    endfunction

    function automatic logic [PIX_W-1:0] blur_pixel(input int px, input int py);
        int               side;
        int               ksz;
        int               nx;
        int               ny;
        logic [63:0]      acc [CH_COUNT];
        logic [63:0]      w;
        logic [63:0]      v;
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] res;
        side = eff_side();
        ksz = 2 * cfg_radius + 1;
        for (int ch = 0; ch < CH_COUNT; ch++) acc[ch] = '0;
        for (int ky = 0; ky < ksz; ky++) begin
            ny = clamp_coord(py + ky - cfg_radius, side);
            for (int kx = 0; kx < ksz; kx++) begin
                nx = clamp_coord(px + kx - cfg_radius, side);
                w = 64'(kernel_mem[TAP_IDX_W'(ky * ksz + kx)]);
                pix = frame_mem[pix_addr(nx, ny)];
                for (int ch = 0; ch < CH_COUNT; ch++) begin
                    acc[ch] += w * 64'(pix[ch*CH_W +: CH_W]);
                end
            end
        end
        for (int ch = 0; ch < CH_COUNT; ch++) begin
            v = acc[ch] >> COEF_FRAC_BITS;
            res[ch*CH_W +: CH_W] = (v > 255) ? {CH_W{1'b1}} : v[CH_W-1:0];
        end
        return res;
    endfunction

    function automatic void predict_item(input t_blur_cmd it);
        t_blur_result res;
        case (it.command)
            CMD_LOAD_COEF: begin
                if (it.coef_index < TAP_COUNT) kernel_mem[it.coef_index] = it.coef_value;
            end
            CMD_LOAD_PIX: begin
                frame_mem[{it.pos_y, it.pos_x}] = it.pixel_rgba;
            end
            CMD_READ: begin
                res.out_x = it.pos_x;
                res.out_y = it.pos_y;
                res.blurred_rgba = blur_pixel(int'(it.pos_x), int'(it.pos_y));
                blurred_q.push_back(res);
            end
            default: begin
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
                                   input logic [PIX_W-1:0] exp_val);
        if (err_count < MAX_REPORTS) begin
            $display("mismatch in %s: got %h, want %h at %0t", what, got, exp_val, $time);
        end
        err_count++;
    endtask

    function automatic t_blur_cmd rand_item();
        t_blur_cmd it;
        it.command    = CMD_W'($urandom_range(0, 3));
        it.pos_x      = COORD_W'($urandom_range(0, FRAME_SIDE - 1));
        it.pos_y      = COORD_W'($urandom_range(0, FRAME_SIDE - 1));
        it.pixel_rgba = $urandom;
        it.coef_index = TAP_IDX_W'($urandom_range(0, 255));
        it.coef_value = COEF_W'($urandom_range(0, COEF_MAX));
        return it;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return '1;
        if (roll < 20) return '0;
        return $urandom;
    endfunction

    function automatic logic [COEF_W-1:0] pick_weight(input int taps);
        int roll;
        int hi;
        roll = $urandom_range(0, 99);
        hi = (2 * UNITY) / taps;
        if (hi > COEF_MAX) hi = COEF_MAX;
        if (roll < 80) return COEF_W'($urandom_range(0, hi));
        if (roll < 90) return COEF_W'($urandom_range(0, COEF_MAX));
        if (roll < 95) return COEF_W'(UNITY);
        return '0;
    endfunction

    function automatic void push_item(input t_blur_cmd it);
        if (it.command == CMD_LOAD_PIX) gen_pix_set[{it.pos_y, it.pos_x}] = 1'b1;
        if (it.command == CMD_LOAD_COEF && it.coef_index < TAP_COUNT) begin
            gen_tap_set[it.coef_index] = 1'b1;
        end
        cmd_q.push_back(it);
        queued_total++;
    endfunction

    function automatic void push_pixel(input int x, input int y, input logic [PIX_W-1:0] p);
        t_blur_cmd it;
        it = rand_item();
        it.command = CMD_LOAD_PIX;
        it.pos_x = COORD_W'(x);
        it.pos_y = COORD_W'(y);
        it.pixel_rgba = p;
        push_item(it);
    endfunction

    function automatic void push_tap(input int idx, input logic [COEF_W-1:0] w);
        t_blur_cmd it;
        it = rand_item();
        it.command = CMD_LOAD_COEF;
        it.coef_index = TAP_IDX_W'(idx);
        it.coef_value = w;
        push_item(it);
    endfunction

    // Loads every tap and neighbor the window will touch that was never written,
    // then issues the read itself.
    function automatic void queue_blur_read(input int x, input int y);
        int        side;
        int        ksz;
        int        nx;
        int        ny;
        t_blur_cmd it;
        side = eff_side();
        ksz = 2 * cfg_radius + 1;
        for (int t = 0; t < ksz * ksz; t++) begin
            if (!gen_tap_set[TAP_IDX_W'(t)]) push_tap(t, pick_weight(ksz * ksz));
        end
        for (int dy = -cfg_radius; dy <= cfg_radius; dy++) begin
            for (int dx = -cfg_radius; dx <= cfg_radius; dx++) begin
                ny = clamp_coord(y + dy, side);
                nx = clamp_coord(x + dx, side);
                if (!gen_pix_set[pix_addr(nx, ny)]) push_pixel(nx, ny, rand_pixel());
            end
        end
        it = rand_item();
        it.command = CMD_READ;
        it.pos_x = COORD_W'(x);
        it.pos_y = COORD_W'(y);
        push_item(it);
        last_x = x;
        last_y = y;
    endfunction

    function automatic void random_phase(input int quota);
        int        start;
        int        roll;
        int        taps;
        int        x;
        int        y;
        t_blur_cmd it;
        start = queued_total;
        taps = (2 * cfg_radius + 1) * (2 * cfg_radius + 1);
        while (queued_total - start < quota) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                if ($urandom_range(0, 99) < 60) begin
                    x = clamp_coord(last_x + int'($urandom_range(0, 4)) - 2, FRAME_SIDE);
                    y = clamp_coord(last_y + int'($urandom_range(0, 4)) - 2, FRAME_SIDE);
                end else if ($urandom_range(0, 99) < 70) begin
                    x = int'($urandom_range(0, eff_side() - 1));
                    y = int'($urandom_range(0, eff_side() - 1));
                end else begin
                    x = int'($urandom_range(0, FRAME_SIDE - 1));
                    y = int'($urandom_range(0, FRAME_SIDE - 1));
                end
                queue_blur_read(x, y);
            end else if (roll < 75) begin
                push_pixel(int'($urandom_range(0, FRAME_SIDE - 1)),
                           int'($urandom_range(0, FRAME_SIDE - 1)), rand_pixel());
            end else if (roll < 90) begin
                push_tap(int'($urandom_range(0, taps - 1)), pick_weight(taps));
            end else if (roll < 95) begin
                it = rand_item();
                it.command = CMD_LOAD_COEF;
                push_item(it);
            end else begin
                it = rand_item();
                it.command = CMD_UNUSED;
                push_item(it);
            end
        end
    endfunction

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_CANVAS_SIZE) begin
            cfg_canvas = int'(data);
        end else begin
            cfg_radius = int'(data[RAD_W-1:0]);
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (cmd_q.size() != 0 || pix_in.valid || blurred_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_in.valid <= 1'b0;
        end else if (!pix_in.valid || pix_in.ready) begin
            if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                drv_item = cmd_q.pop_front();
                pix_in.valid      <= 1'b1;
                pix_in.command    <= drv_item.command;
                pix_in.pos_x      <= drv_item.pos_x;
                pix_in.pos_y      <= drv_item.pos_y;
                pix_in.pixel_rgba <= drv_item.pixel_rgba;
                pix_in.coef_index <= drv_item.coef_index;
                pix_in.coef_value <= drv_item.coef_value;
            end else begin
                pix_in.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        pix_out.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pix_in.valid && pix_in.ready) begin
                seen_cmd.command    = pix_in.command;
                seen_cmd.pos_x      = pix_in.pos_x;
                seen_cmd.pos_y      = pix_in.pos_y;
                seen_cmd.pixel_rgba = pix_in.pixel_rgba;
                seen_cmd.coef_index = pix_in.coef_index;
                seen_cmd.coef_value = pix_in.coef_value;
                predict_item(seen_cmd);
            end
            if (pix_out.valid && pix_out.ready) begin
                if (blurred_q.size() == 0) begin
                    report_mismatch("result with no read pending", pix_out.blurred_rgba, '0);
                end else begin
                    want = blurred_q.pop_front();
                    if (pix_out.out_x !== want.out_x) begin
                        report_mismatch("out_x", PIX_W'(pix_out.out_x), PIX_W'(want.out_x));
                    end
                    if (pix_out.out_y !== want.out_y) begin
                        report_mismatch("out_y", PIX_W'(pix_out.out_y), PIX_W'(want.out_y));
                    end
                    if (pix_out.blurred_rgba !== want.blurred_rgba) begin
                        report_mismatch("blurred_rgba", pix_out.blurred_rgba, want.blurred_rgba);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int                    phase_canvas [NUM_PHASES];
        int                    phase_radius [NUM_PHASES];
        logic [COEF_W-1:0]     w;
        t_blur_cmd             it;
        logic [CFG_DATA_W-1:0] rad_data;
        int                    quota;

        phase_canvas = '{1, 64, 0, 8, 127, 5, 64, 0, 0, 64};
        phase_radius = '{0, 7, 2, 7, 3, 1, 0, 0, 0, 1};
        phase_canvas[7] = int'($urandom_range(1, FRAME_SIDE));
        phase_radius[7] = int'($urandom_range(0, MAX_RADIUS));
        phase_canvas[8] = int'($urandom_range(0, (1 << CFG_DATA_W) - 1));
        phase_radius[8] = int'($urandom_range(0, MAX_RADIUS));

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_CANVAS_SIZE;
        i_cfg_data        = '0;
        pix_in.valid      = 1'b0;
        pix_in.command    = CMD_LOAD_COEF;
        pix_in.pos_x      = '0;
        pix_in.pos_y      = '0;
        pix_in.pixel_rgba = '0;
        pix_in.coef_index = '0;
        pix_in.coef_value = '0;
        pix_out.ready     = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset settings: taps off the store, an unknown
        // command, a full-scale tap that saturates, and reads at both corners.
        push_tap(255, COEF_W'(COEF_MAX));
        push_tap(TAP_COUNT, '0);
        it = rand_item();
        it.command = CMD_UNUSED;
        push_item(it);
        for (int t = 0; t < 9; t++) begin
            case (t)
                0: w = COEF_W'(COEF_MAX);
                4: w = COEF_W'(UNITY);
                8: w = '0;
                default: w = COEF_W'($urandom_range(0, UNITY / 4));
            endcase
            push_tap(t, w);
        end
        push_pixel(0, 0, '1);
        push_pixel(FRAME_SIDE - 1, FRAME_SIDE - 1, '0);
        queue_blur_read(0, 0);
        queue_blur_read(FRAME_SIDE - 1, FRAME_SIDE - 1);

        // Window fills can be large, so each phase gets a share of what is left
        // of the overall item budget.
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            rad_data = CFG_DATA_W'(($urandom_range(0, CFG_PAD_MAX) << RAD_W)
                                   | phase_radius[p]);
            write_reg(CFG_CANVAS_SIZE, CFG_DATA_W'(phase_canvas[p]));
            write_reg(CFG_BLUR_RADIUS, rad_data);
            quota = (NUM_PHASES * PHASE_ITEMS - queued_total) / (NUM_PHASES - p);
            if (quota < MIN_PHASE_ITEMS) quota = MIN_PHASE_ITEMS;
            random_phase(quota);
        end

        wait_idle();
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/rgbb_pkg.sv
rtl/core/rgbb_in_if.sv
rtl/core/rgbb_out_if.sv
rtl/core/rgbb_ctrl.sv
rtl/core/rgbb_dp.sv
rtl/core/rgba_gaussian_blur_clamped.sv
dv/tb.sv
